/* rtl/cellular_automaton_3d_generations_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef CELLULAR_AUTOMATON_3D_GENERATIONS_MACROS_SVH
`define CELLULAR_AUTOMATON_3D_GENERATIONS_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CA3G_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ca3g check failed");

// Condition in one cycle implies a consequence in the next.
`define CA3G_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ca3g sequence check failed");

`endif

/* rtl/ca3g_pkg.sv */
package ca3g_pkg;

  localparam int unsigned MaxSpan   = 32;
  localparam int unsigned StateBits = 4;
  localparam int unsigned CoordBits = $clog2(MaxSpan);
  localparam int unsigned SpanBits  = CoordBits + 1;
  localparam int unsigned CellBits  = 3 * CoordBits;
  localparam int unsigned CellCount = MaxSpan * MaxSpan * MaxSpan;
  localparam int unsigned RuleBits  = 27;
  localparam int unsigned CntBits   = $clog2(RuleBits);
  localparam int unsigned CfgBits   = 27;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SPAN      = 3'd0,
    REG_MAX_STATE = 3'd1,
    REG_SURVIVE   = 3'd2,
    REG_BIRTH     = 3'd3,
    REG_MOORE     = 3'd4,
    REG_WRAP      = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic                 ok;
    logic [CoordBits-1:0] coord;
  } nb_coord_t;

  // Neighbor coordinate along one axis; off 0,1,2 means -1,0,+1.
  function automatic nb_coord_t nb_coord(input logic [CoordBits-1:0] c,
                                         input logic [1:0]           off,
                                         input logic [SpanBits-1:0]  w,
                                         input logic                 wrap);
    logic [SpanBits-1:0] t;
    nb_coord_t           r;
    t = {1'b0, c} + SpanBits'(off);
    r.ok    = 1'b1;
    r.coord = CoordBits'(t - SpanBits'(1));
    if (t == '0) begin
      r.ok    = wrap;
      r.coord = CoordBits'(w - SpanBits'(1));
    end else if (t == w + SpanBits'(1)) begin
      r.ok    = wrap;
      r.coord = '0;
    end
    return r;
  endfunction

endpackage

/* rtl/ca3g_ram.sv */
module ca3g_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/cellular_automaton_3d_generations.sv */
// 3D generations cellular automaton over a cube of up to 32 cells a side.
// Input channel (valid/ready): mode_i with cell coordinates and a value.
// Output channel (valid/ready): one item per input, read_value_o and
// done_mode_o. Config port: cfg_we_i writes cfg_idx_i at once. Writing only
// while idle is the user's duty; the block leaves that check to the user.
// A step reads the 27 cells around each cell one per cycle from the
// single read port of the grid memory, so that port sets the step time;
// the new states go to a scratch memory and are copied back one per cycle.
// After reset the grid memory is swept to zero, and no item is accepted
// until the sweep ends; config writes are taken throughout.
// A result sits in an output register; while it waits for out_ready_i
// the block is idle again and takes the next item. An item that finishes
// while the output register is still full holds until it drains.
`include "cellular_automaton_3d_generations_macros.svh"

module cellular_automaton_3d_generations
  import ca3g_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [CoordBits-1:0]  cell_x_i,
  input  logic [CoordBits-1:0]  cell_y_i,
  input  logic [CoordBits-1:0]  cell_z_i,
  input  logic [StateBits-1:0]  cell_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StateBits-1:0]  read_value_o,
  output logic [1:0]            done_mode_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RDW   = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_TALLY = 9'b000001000,
    ST_WB    = 9'b000010000,
    ST_COPY  = 9'b000100000,
    ST_CPEND = 9'b001000000,
    ST_INIT  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [SpanBits-1:0]  span_q;
  logic [StateBits-1:0] max_q;
  logic [RuleBits-1:0]  surv_q, birth_q;
  logic                 moore_q, wrap_q;

  logic [1:0]           mode_q, mode_d;
  logic                 inside_q, inside_d;
  logic [StateBits-1:0] val_q, val_d;
  logic [CoordBits-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [1:0]           ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [StateBits-1:0] s_q, s_d;
  logic [CellBits-1:0]  clr_q, clr_d;
  logic                 rd_vld_q, rd_cnt_q, rd_ctr_q;
  logic                 cp_vld_q;
  logic [CellBits-1:0]  cp_addr_q;
  logic                 out_valid_q, out_valid_d;
  logic [StateBits-1:0] out_val_q, out_val_d;
  logic [1:0]           out_mode_q, out_mode_d;

  logic [SpanBits-1:0]  w;
  logic [CoordBits-1:0] wm1;
  logic [StateBits-1:0] full;
  logic                 inside_in;
  logic [StateBits-1:0] clamp_val;
  nb_coord_t            nbx, nby, nbz;
  logic                 is_center, is_axis, nb_count;
  logic                 last_off, last_cell;
  logic [CellBits-1:0]  cell_addr, nb_addr, in_addr;
  logic [StateBits-1:0] new_state;

  logic                 cur_we, nxt_we;
  logic [CellBits-1:0]  cur_waddr, cur_raddr;
  logic [StateBits-1:0] cur_wdata, cur_rdata, nxt_rdata;

  // Effective span and full state.
  always_comb begin
    priority if (span_q == '0) begin
      w = SpanBits'(1);
    end else if (span_q > SpanBits'(MaxSpan)) begin
      w = SpanBits'(MaxSpan);
    end else begin
      w = span_q;
    end
  end
  assign wm1  = CoordBits'(w - SpanBits'(1));
  assign full = (max_q == '0) ? StateBits'(1) : max_q;

  assign inside_in = ({1'b0, cell_x_i} < w) && ({1'b0, cell_y_i} < w)
                     && ({1'b0, cell_z_i} < w);
  assign clamp_val = (cell_value_i > full) ? full : cell_value_i;
  assign in_addr   = {cell_z_i, cell_y_i, cell_x_i};
  assign cell_addr = {cz_q, cy_q, cx_q};

  assign nbx = nb_coord(cx_q, ox_q, w, wrap_q);
  assign nby = nb_coord(cy_q, oy_q, w, wrap_q);
  assign nbz = nb_coord(cz_q, oz_q, w, wrap_q);
  assign nb_addr = {nbz.coord, nby.coord, nbx.coord};

  always_comb begin
    logic ax, ay, az;
    ax = (ox_q != 2'd1);
    ay = (oy_q != 2'd1);
    az = (oz_q != 2'd1);
    is_center = !ax && !ay && !az;
    is_axis   = (ax ^ ay ^ az) && !(ax && ay && az);
    nb_count  = nbx.ok && nby.ok && nbz.ok && (moore_q ? !is_center : is_axis);
  end

  assign last_off  = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);
  assign last_cell = (cx_q == wm1) && (cy_q == wm1) && (cz_q == wm1);

  always_comb begin
    priority if (s_q == full) begin
      new_state = surv_q[cnt_q] ? full : full - StateBits'(1);
    end else if (s_q != '0) begin
      new_state = s_q - StateBits'(1);
    end else begin
      new_state = birth_q[cnt_q] ? full : '0;
    end
  end

  assign cur_raddr = (state_q == ST_SCAN) ? nb_addr : in_addr;
  assign nxt_we    = (state_q == ST_WB);

  ca3g_ram #(.Width(StateBits), .Depth(CellCount)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  ca3g_ram #(.Width(StateBits), .Depth(CellCount)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (cell_addr),
    .wdata_i (new_state),
    .raddr_i (cell_addr),
    .rdata_o (nxt_rdata)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign done_mode_o  = out_mode_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    inside_d    = inside_q;
    val_d       = val_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_mode_d  = out_mode_q;
    cur_we      = 1'b0;
    cur_waddr   = in_addr;
    cur_wdata   = clamp_val;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Tally the neighbor read issued last cycle; the center read loads s_q.
    if (rd_vld_q) begin
      if (rd_cnt_q && (cur_rdata == full)) begin
        cnt_d = cnt_q + CntBits'(1);
      end
      if (rd_ctr_q) begin
        s_d = cur_rdata;
      end
    end

    // Finish the copy-back write of the scratch entry read last cycle.
    if (cp_vld_q) begin
      cur_we    = 1'b1;
      cur_waddr = cp_addr_q;
      cur_wdata = nxt_rdata;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_i;
          val_d  = '0;
          unique case (mode_i)
            MODE_WRITE: begin
              cur_we  = inside_in;
              state_d = ST_FIN;
            end
            MODE_READ: begin
              inside_d = inside_in;
              state_d  = ST_RDW;
            end
            MODE_STEP: begin
              cx_d    = '0;
              cy_d    = '0;
              cz_d    = '0;
              ox_d    = '0;
              oy_d    = '0;
              oz_d    = '0;
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            MODE_CLEAR: begin
              clr_d   = '0;
              state_d = ST_INIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDW: begin
        val_d   = inside_q ? cur_rdata : '0;
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        // Advance the offset, x fastest.
        if (ox_q != 2'd2) begin
          ox_d = ox_q + 2'd1;
        end else begin
          ox_d = '0;
          if (oy_q != 2'd2) begin
            oy_d = oy_q + 2'd1;
          end else begin
            oy_d = '0;
            oz_d = oz_q + 2'd1;
          end
        end
        if (last_off) begin
          oz_d    = '0;
          state_d = ST_TALLY;
        end
      end
      ST_TALLY: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        cnt_d = '0;
        ox_d  = '0;
        oy_d  = '0;
        oz_d  = '0;
        if (cx_q != wm1) begin
          cx_d = cx_q + CoordBits'(1);
        end else begin
          cx_d = '0;
          if (cy_q != wm1) begin
            cy_d = cy_q + CoordBits'(1);
          end else begin
            cy_d = '0;
            cz_d = cz_q + CoordBits'(1);
          end
        end
        if (last_cell) begin
          cz_d    = '0;
          state_d = ST_COPY;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_COPY: begin
        if (cx_q != wm1) begin
          cx_d = cx_q + CoordBits'(1);
        end else begin
          cx_d = '0;
          if (cy_q != wm1) begin
            cy_d = cy_q + CoordBits'(1);
          end else begin
            cy_d = '0;
            cz_d = cz_q + CoordBits'(1);
          end
        end
        if (last_cell) begin
          state_d = ST_CPEND;
        end
      end
      ST_CPEND: begin
        state_d = ST_FIN;
      end
      ST_INIT: begin
        cur_we    = 1'b1;
        cur_waddr = clr_q;
        cur_wdata = '0;
        clr_d     = clr_q + CellBits'(1);
        if (clr_q == '1) begin
          state_d = (mode_q == MODE_CLEAR) ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = val_q;
          out_mode_d  = mode_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q  <= SpanBits'(MaxSpan);
      max_q   <= StateBits'(1);
      surv_q  <= '0;
      birth_q <= '0;
      moore_q <= 1'b1;
      wrap_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SPAN:      span_q  <= cfg_wdata_i[SpanBits-1:0];
        REG_MAX_STATE: max_q   <= cfg_wdata_i[StateBits-1:0];
        REG_SURVIVE:   surv_q  <= cfg_wdata_i[RuleBits-1:0];
        REG_BIRTH:     birth_q <= cfg_wdata_i[RuleBits-1:0];
        REG_MOORE:     moore_q <= cfg_wdata_i[0];
        REG_WRAP:      wrap_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      mode_q      <= MODE_WRITE;
      clr_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      cp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      clr_q       <= clr_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      cz_q        <= cz_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      oz_q        <= oz_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      cp_vld_q    <= (state_q == ST_COPY);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q   <= inside_d;
    val_q      <= val_d;
    s_q        <= s_d;
    rd_cnt_q   <= nb_count;
    rd_ctr_q   <= is_center;
    cp_addr_q  <= cell_addr;
    out_val_q  <= out_val_d;
    out_mode_q <= out_mode_d;
  end

  `CA3G_ASSERT(a_cnt_bound, (state_q != ST_WB) || (cnt_q <= (moore_q ? 5'd26 : 5'd6)))
  `CA3G_ASSERT(a_no_grid_write_in_scan, (state_q != ST_SCAN) || !cur_we)
  `CA3G_ASSERT_NEXT(a_fin_loads, (state_q == ST_FIN) && (!out_valid_q || out_ready_i), out_valid_q)
  `CA3G_ASSERT_NEXT(a_tally_follows_scan, (state_q == ST_SCAN), rd_vld_q == 1'b1)

endmodule
